>>> hdl/crcdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcdf_pkg: shared definitions for the CRC-16 packet deframer
// Sync byte values, frame phase codes, result event codes, stream widths and
// the byte-wide MSB-first CRC-16 update.
// ----------------------------------------------------------------------------
package crcdf_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h21;  // '!'
  localparam logic [7:0] SYNC_SECOND = 8'h24;  // '$'
  localparam logic [15:0] CRC_TOP_BIT = 16'h8000;

  localparam logic [15:0] POLY_RESET = 16'h1021;
  localparam logic [15:0] INIT_RESET = 16'hFFFF;

  // Configuration register indexes.
  localparam logic REG_POLY = 1'b0;
  localparam logic REG_INIT = 1'b1;

  // Frame phases.
  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_SYNC2   = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_DEV     = 3'd3;
  localparam logic [2:0] PH_MSG     = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_CHK_LO  = 3'd6;
  localparam logic [2:0] PH_CHK_HI  = 3'd7;

  // Result event codes.
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_PAYLOAD  = 2'd1;
  localparam logic [1:0] EV_GOOD     = 2'd2;
  localparam logic [1:0] EV_BAD_CRC  = 2'd3;

  localparam int OUT_DATA_W = 40;

  // Fold one byte into the running CRC, most significant bit first.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                           input logic [7:0]  data,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP_BIT) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/crc16_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_packet_deframer: CRC-16 checked packet deframer
// Hunts for the "!$" sync pair, parses length, device id and message id,
// passes payload bytes through and checks the trailing little-endian CRC-16.
// ----------------------------------------------------------------------------
// Usage:
// Received bytes enter on the s_axis channel, one item per byte. Every
// accepted byte produces exactly one item on the m_axis channel: its tuser
// carries the event (nothing, payload byte, good frame, bad-CRC frame) and
// its tdata carries the payload byte, its index and the header fields.
// The frame state and the CRC update sit in one short combinational path
// between the frame state registers and the output register, so the result
// for a byte appears on m_axis in the cycle after it is accepted, and the block
// takes one byte every cycle as long as the output is drained.
// s_axis_tready is high whenever the output register is empty or is being
// taken in the same cycle; when the receiver stalls, the result waits in
// the output register and input stops after that single item.
// The polynomial and initial value are written through the cfg port; the user
// must do so only while no frame is in flight, as the block does not enforce it.
// Reset (rst, synchronous) returns the deframer to hunting, empties the output
// register and restores polynomial 0x1021 and initial value 0xFFFF.
// ----------------------------------------------------------------------------
module crc16_packet_deframer
  import crcdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_data,
  // Received bytes. tdata: rx_byte[7:0].
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,
  // Results. tdata: data_byte[7:0], byte_index[15:8], frame_length[23:16],
  // node_id[31:24], message_id[39:32]. tuser: event_res[1:0].
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]            m_axis_tuser
);

  // Configuration registers.
  logic [15:0] crc_polynomial;
  logic [15:0] crc_initial;

  // Frame state.
  logic [2:0]  phase, phase_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [7:0]  length_seen, length_seen_next;
  logic [7:0]  device_seen, device_seen_next;
  logic [7:0]  message_seen, message_seen_next;
  logic [7:0]  check_low, check_low_next;

  // Result fields for the byte now on the input.
  logic [1:0]  ev;
  logic [7:0]  res_data;
  logic [7:0]  res_index;
  logic        hdr;
  logic [15:0] crc_folded;
  logic        accept;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // One CRC unit serves every phase; each phase decides whether to keep it.
  assign crc_folded = crc_fold((phase == PH_HUNT) ? crc_initial : running_crc,
                               s_axis_tdata, crc_polynomial);

  always_comb begin
    phase_next         = phase;
    running_crc_next   = running_crc;
    payload_count_next = payload_count;
    length_seen_next   = length_seen;
    device_seen_next   = device_seen;
    message_seen_next  = message_seen;
    check_low_next     = check_low;
    ev                 = EV_NONE;
    res_data           = 8'h00;
    res_index          = 8'h00;
    hdr                = 1'b0;
    unique case (phase)
      PH_HUNT: begin
        payload_count_next = 8'h00;
        if (s_axis_tdata == SYNC_FIRST) begin
          running_crc_next = crc_folded;
          phase_next       = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        // A wrong second byte is dropped, not retried as a first sync byte.
        if (s_axis_tdata == SYNC_SECOND) begin
          running_crc_next = crc_folded;
          phase_next       = PH_LEN;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_LEN: begin
        length_seen_next = s_axis_tdata;
        running_crc_next = crc_folded;
        phase_next       = PH_DEV;
      end
      PH_DEV: begin
        device_seen_next = s_axis_tdata;
        running_crc_next = crc_folded;
        phase_next       = PH_MSG;
      end
      PH_MSG: begin
        message_seen_next  = s_axis_tdata;
        running_crc_next   = crc_folded;
        payload_count_next = 8'h00;
        phase_next         = (length_seen == 8'h00) ? PH_CHK_LO : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (payload_count < length_seen) begin
          running_crc_next   = crc_folded;
          ev                 = EV_PAYLOAD;
          res_data           = s_axis_tdata;
          res_index          = payload_count;
          hdr                = 1'b1;
          payload_count_next = payload_count + 8'd1;
          if (payload_count_next >= length_seen) begin
            phase_next = PH_CHK_LO;
          end
        end else begin
          check_low_next = s_axis_tdata;
          phase_next     = PH_CHK_HI;
        end
      end
      PH_CHK_LO: begin
        check_low_next = s_axis_tdata;
        phase_next     = PH_CHK_HI;
      end
      PH_CHK_HI: begin
        ev         = ({s_axis_tdata, check_low} == running_crc) ? EV_GOOD : EV_BAD_CRC;
        hdr        = 1'b1;
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_polynomial <= POLY_RESET;
      crc_initial    <= INIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLY: crc_polynomial <= cfg_data;
        REG_INIT: crc_initial    <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      running_crc   <= 16'h0000;
      payload_count <= 8'h00;
      length_seen   <= 8'h00;
      device_seen   <= 8'h00;
      message_seen  <= 8'h00;
      check_low     <= 8'h00;
    end else if (accept) begin
      phase         <= phase_next;
      running_crc   <= running_crc_next;
      payload_count <= payload_count_next;
      length_seen   <= length_seen_next;
      device_seen   <= device_seen_next;
      message_seen  <= message_seen_next;
      check_low     <= check_low_next;
    end
  end

  // Output register: loads on every accepted byte, empties when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tuser <= ev;
      m_axis_tdata <= {hdr ? message_seen : 8'h00,
                       hdr ? device_seen  : 8'h00,
                       hdr ? length_seen  : 8'h00,
                       res_index,
                       res_data};
    end
  end

`ifndef ASSERT_OFF
  // A passed-through payload byte always lies inside the announced length.
  a_index_in_frame: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == EV_PAYLOAD |->
      m_axis_tdata[15:8] < m_axis_tdata[23:16])
    else $error("payload byte index outside frame length");

  // The payload phase is only entered with bytes still owed.
  a_payload_owed: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> payload_count < length_seen)
    else $error("payload phase with no bytes owed");

  // A byte taken while hunting never yields an event.
  a_hunt_quiet: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_HUNT |=> m_axis_tvalid && m_axis_tuser == EV_NONE)
    else $error("event reported while hunting");

  // The high check byte closes the frame with a verdict and resumes hunting.
  a_frame_close: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_CHK_HI |=>
      phase == PH_HUNT && (m_axis_tuser == EV_GOOD || m_axis_tuser == EV_BAD_CRC))
    else $error("frame not closed after check bytes");
`endif

endmodule

>>> test/tb_crc16_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc16_packet_deframer: self-checking testbench for the packet deframer
// Streams received bytes into the deframer and predicts, byte by byte, the
// event that each one should produce. The prediction is kept in a queue and
// is compared in order with every result item taken from the output. The
// directed tests cover header and payload extremes, zero length, bad CRC,
// sync recovery and register writes in the middle of a frame. The random
// test runs well-formed, corrupted and noise traffic under several
// polynomial and initial value settings, with sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module tb_crc16_packet_deframer;
  import crcdf_pkg::*;

  localparam int CYCLE_LIMIT  = 250000;
  localparam int RANDOM_ITEMS = 1750;
  localparam int NUM_SETTINGS = 6;

  // One result item, split into its fields.
  typedef struct packed {
    logic [1:0] ev;
    logic [7:0] data;
    logic [7:0] idx;
    logic [7:0] len;
    logic [7:0] dev;
    logic [7:0] msg;
  } deframe_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = REG_POLY;
  logic [15:0]           cfg_data = 16'h0000;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'h00;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;

  // Expected result items, oldest first.
  deframe_result_t expected_results[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  int burst_left = 0;
  int gap_mode = 0;    // 0 no gaps, 1 long bursts, 2 short bursts
  int stall_mode = 0;  // 0 always ready, 1 random, 2 periodic, 3 sparse
  int stall_tick = 0;

  // Shadow of the configuration registers.
  logic [15:0] poly_cfg = POLY_RESET;
  logic [15:0] init_cfg = INIT_RESET;

  // Shadow of the frame state.
  logic [2:0]  pr_phase = PH_HUNT;
  logic [15:0] pr_crc = 16'h0000;
  logic [7:0]  pr_count = 8'h00;
  logic [7:0]  pr_len = 8'h00;
  logic [7:0]  pr_dev = 8'h00;
  logic [7:0]  pr_msg = 8'h00;
  logic [7:0]  pr_chk_lo = 8'h00;

  crc16_packet_deframer i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bit-serial form of the MSB-first CRC-16: each data bit, from the top,
  // meets the CRC top bit and decides whether the polynomial is applied.
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0} ^ (fb ? poly_cfg : 16'h0000);
    end
    return r;
  endfunction

  // Advance the shadow frame state by one byte and return the result item
  // that the deframer should produce for it.
  function automatic deframe_result_t deframe_step(input logic [7:0] b);
    deframe_result_t r;
    logic            hdr;
    r = '0;
    hdr = 1'b0;
    case (pr_phase)
      PH_HUNT: begin
        pr_count = 8'h00;
        if (b == SYNC_FIRST) begin
          // The initial value is taken at the first sync byte only.
          pr_crc = crc16_byte(init_cfg, b);
          pr_phase = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        // A wrong second byte drops back to hunting and is not rechecked.
        if (b == SYNC_SECOND) begin
          pr_crc = crc16_byte(pr_crc, b);
          pr_phase = PH_LEN;
        end else begin
          pr_phase = PH_HUNT;
        end
      end
      PH_LEN: begin
        pr_len = b;
        pr_crc = crc16_byte(pr_crc, b);
        pr_phase = PH_DEV;
      end
      PH_DEV: begin
        pr_dev = b;
        pr_crc = crc16_byte(pr_crc, b);
        pr_phase = PH_MSG;
      end
      PH_MSG: begin
        pr_msg = b;
        pr_crc = crc16_byte(pr_crc, b);
        pr_count = 8'h00;
        pr_phase = (pr_len == 8'h00) ? PH_CHK_LO : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (pr_count < pr_len) begin
          pr_crc = crc16_byte(pr_crc, b);
          r.ev = EV_PAYLOAD;
          r.data = b;
          r.idx = pr_count;
          hdr = 1'b1;
          pr_count = pr_count + 8'd1;
          if (pr_count >= pr_len) begin
            pr_phase = PH_CHK_LO;
          end
        end else begin
          pr_chk_lo = b;
          pr_phase = PH_CHK_HI;
        end
      end
      PH_CHK_LO: begin
        pr_chk_lo = b;
        pr_phase = PH_CHK_HI;
      end
      default: begin
        // Check high byte: the received value is low byte first.
        r.ev = ({b, pr_chk_lo} == pr_crc) ? EV_GOOD : EV_BAD_CRC;
        hdr = 1'b1;
        pr_phase = PH_HUNT;
      end
    endcase
    if (hdr) begin
      r.len = pr_len;
      r.dev = pr_dev;
      r.msg = pr_msg;
    end
    return r;
  endfunction

  // Mostly short payloads, some medium ones and now and then the largest.
  function automatic logic [7:0] frame_len_pick();
    int k;
    k = $urandom_range(0, 99);
    if (k < 1) begin
      return 8'hFF;
    end else if (k < 4) begin
      return 8'($urandom_range(9, 64));
    end
    return 8'($urandom_range(0, 8));
  endfunction

  // Send one byte, with a gap before it when a burst has run out, and hold
  // it until the deframer accepts it.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (gap_mode != 0 && burst_left <= 0) begin
      gap = (gap_mode == 1) ? $urandom_range(1, 5) : $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = (gap_mode == 1) ? $urandom_range(1, 16) : $urandom_range(1, 3);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
    bytes_sent++;
    expected_results.push_back(deframe_step(b));
  endtask

  // Stop sending and wait until every expected result item has arrived.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_POLY) begin
      poly_cfg = val;
    end else begin
      init_cfg = val;
    end
  endtask

  // Send the check value of the frame now in progress, taken from the shadow
  // CRC, optionally with one bit flipped.
  task automatic send_check(input logic bad);
    logic [15:0] c;
    c = pr_crc;
    if (bad) begin
      c = c ^ (16'h0001 << $urandom_range(0, 15));
    end
    send_byte(c[7:0]);
    send_byte(c[15:8]);
  endtask

  // Build a whole frame with a random payload and its CRC under the current
  // settings. A non-negative flip_pos flips one bit of the byte at that position, modulo the frame size.
  task automatic send_frame(input logic [7:0] len, input logic [7:0] dev,
                            input logic [7:0] msg, input int flip_pos);
    logic [7:0]  frame_bytes[$];
    logic [15:0] c;
    int          pos;
    frame_bytes = {SYNC_FIRST, SYNC_SECOND, len, dev, msg};
    for (int i = 0; i < int'(len); i++) begin
      frame_bytes.push_back(8'($urandom));
    end
    c = init_cfg;
    foreach (frame_bytes[i]) begin
      c = crc16_byte(c, frame_bytes[i]);
    end
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
    if (flip_pos >= 0) begin
      pos = flip_pos % frame_bytes.size();
      frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i]);
    end
  endtask

  // Frames under the reset settings: payload and header extremes, then a
  // zero-length frame whose check value is wrong.
  task automatic test_reset_frames();
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'd2);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_check(1'b0);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_check(1'b1);
    drain();
  endtask

  // A repeated first sync byte counts as a wrong second byte, so the
  // following second sync byte is seen while hunting and is ignored.
  task automatic test_sync_recovery();
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    drain();
  endtask

  // Register writes while a frame is open: the new polynomial applies to
  // the bytes still to come, the new initial value only to the next frame.
  task automatic test_midframe_config();
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'd1);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    drain();
    write_reg(REG_POLY, 16'h8005);
    send_byte(8'($urandom));
    drain();
    write_reg(REG_INIT, 16'h0000);
    send_check(1'b0);
    drain();
  endtask

  // Random traffic under a range of settings, extremes included. Each
  // setting also picks its own sender and receiver behavior.
  task automatic test_random_traffic();
    logic [15:0] polys[NUM_SETTINGS];
    logic [15:0] inits[NUM_SETTINGS];
    int          stop_at;
    int          pick;
    int          n;
    polys = '{16'h1021, 16'h8005, 16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom)};
    inits = '{16'hFFFF, 16'h0000, 16'($urandom), 16'hFFFF, 16'h0000, 16'($urandom)};
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      drain();
      write_reg(REG_POLY, polys[p]);
      write_reg(REG_INIT, inits[p]);
      gap_mode = p % 3;
      stall_mode = p % 4;
      stop_at = bytes_sent + RANDOM_ITEMS / NUM_SETTINGS;
      while (bytes_sent < stop_at) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          send_frame(frame_len_pick(), 8'($urandom), 8'($urandom), -1);
        end else if (pick < 87) begin
          send_frame(frame_len_pick(), 8'($urandom), 8'($urandom), $urandom_range(0, 300));
        end else begin
          // Noise, rich in sync bytes so that broken starts occur.
          n = $urandom_range(1, 6);
          repeat (n) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
              send_byte(SYNC_FIRST);
            end else if (pick < 4) begin
              send_byte(SYNC_SECOND);
            end else begin
              send_byte(8'($urandom));
            end
          end
        end
      end
    end
    drain();
  endtask

  // Receiver readiness, on a pattern chosen by stall_mode.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= ($urandom_range(0, 99) < 70);
      end
      2: begin
        m_axis_tready <= ((stall_tick % 9) >= 4);
      end
      default: begin
        m_axis_tready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  // Compare every accepted result item with the oldest expectation.
  always @(posedge clk) begin
    deframe_result_t got;
    deframe_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.ev = m_axis_tuser;
      got.data = m_axis_tdata[7:0];
      got.idx = m_axis_tdata[15:8];
      got.len = m_axis_tdata[23:16];
      got.dev = m_axis_tdata[31:24];
      got.msg = m_axis_tdata[39:32];
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: result item with nothing expected: ev=%0d data=%02h idx=%0d len=%0d dev=%02h msg=%02h",
                   $realtime, got.ev, got.data, got.idx, got.len, got.dev, got.msg);
        end
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: mismatch: expected ev=%0d data=%02h idx=%0d len=%0d dev=%02h msg=%02h",
                     $realtime, want.ev, want.data, want.idx, want.len, want.dev, want.msg);
            $display("%0t:           actual   ev=%0d data=%02h idx=%0d len=%0d dev=%02h msg=%02h",
                     $realtime, got.ev, got.data, got.idx, got.len, got.dev, got.msg);
          end
        end
      end
    end
  end

  // Guard against a hang anywhere in the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    gap_mode = 1;
    stall_mode = 1;
    test_reset_frames();
    test_sync_recovery();
    test_midframe_config();
    test_random_traffic();
    // Every byte yields one result item; the extra wait lets any stray result
    // item show up.
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/crcdf_pkg.sv
hdl/crc16_packet_deframer.sv
test/tb_crc16_packet_deframer.sv
